// ----- design/bb5_pkg.sv -----
// ----------------------------------------------------------------------------
// bb5_pkg: shared definitions of the 5x5 binomial blur
// Frame geometry, field widths, the pipeline control record and the
// symmetric five-tap weighting used for both the vertical and the
// horizontal pass of the separable kernel.
// ----------------------------------------------------------------------------
package bb5_pkg;

  localparam int unsigned FrameSize = 256;
  localparam int unsigned PixW      = 8;
  localparam int unsigned ColW      = $clog2(FrameSize);
  // Rows count on past the frame while fill requests drain the tail.
  localparam int unsigned RowW      = $clog2(FrameSize + 3);
  localparam int unsigned VsumW     = 12;
  localparam int unsigned HsumW     = 16;
  localparam int unsigned BlurShift = 8;
  localparam int unsigned Lines     = 4;

  localparam logic [RowW-1:0] RowFrame   = RowW'(FrameSize);
  localparam logic [RowW-1:0] RowLast    = RowW'(FrameSize - 1);
  localparam logic [RowW-1:0] RowInnerHi = RowW'(FrameSize - 3);
  localparam logic [RowW-1:0] RowTwo     = RowW'(2);
  localparam logic [ColW-1:0] ColLast    = ColW'(FrameSize - 1);
  localparam logic [ColW-1:0] ColInnerHi = ColW'(FrameSize - 3);
  localparam logic [ColW-1:0] ColTwo     = ColW'(2);

  typedef struct packed {
    logic emit;
    logic interior;
    logic frame_end;
  } bb5_flags_t;

  typedef struct packed {
    logic            push;
    bb5_flags_t      flags;
    logic [ColW-1:0] col;
  } bb5_item_t;

  // Weighted sum with taps 1, 4, 6, 4, 1.
  function automatic logic [HsumW-1:0] tap_sum5(input logic [4:0][VsumW-1:0] v);
    logic [HsumW-1:0] e0, e1, e2, e3, e4;
    e0 = HsumW'(v[0]);
    e1 = HsumW'(v[1]);
    e2 = HsumW'(v[2]);
    e3 = HsumW'(v[3]);
    e4 = HsumW'(v[4]);
    return e0 + (e1 << 2) + (e2 << 2) + (e2 << 1) + (e3 << 2) + e4;
  endfunction

endpackage

// ----- design/bb5_stream_if.sv -----
// ----------------------------------------------------------------------------
// bb5 stream interfaces
// Valid/ready channels for incoming pixels and outgoing blurred pixels.
// ----------------------------------------------------------------------------
interface bb5_in_if import bb5_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [PixW-1:0] pixel_in;

  modport source (output valid, output kind, output pixel_in, input ready);
  modport sink   (input valid, input kind, input pixel_in, output ready);
endinterface

interface bb5_out_if import bb5_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_out;
  logic            frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ----- design/binomial_blur_5x5.sv -----
// ----------------------------------------------------------------------------
// binomial_blur_5x5: one pass of a 5x5 binomial blur over a streamed frame
// Pipeline: three register stages; the request completing a window loads the
// line store stage, then the window stage, then the output register.
// In stream terms a pixel leaves 2*FrameSize+2 requests after it entered, and
// fill requests push out the tail.
// Throughput: one request per cycle; the line store is read at one column and
// written at another in the same cycle, and the pipeline stalls only while the
// output register holds a pixel that the sink has not taken.
// Reset clears the positions and the pipeline valid bits; the line store is
// not cleared, as no output ever depends on a column not yet written.
// ----------------------------------------------------------------------------
module binomial_blur_5x5 import bb5_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bb5_in_if.sink    in_i,
  bb5_out_if.source out_o
);

  // The whole pipeline moves together; it stops only while the output
  // register holds a pixel that the sink has not yet taken.
  logic             adv, accept, load;
  logic [PixW-1:0]  pixel;
  bb5_item_t        item;

  logic             b_valid;
  bb5_flags_t       b_flags;
  logic [VsumW-1:0] vsum;
  logic [PixW-1:0]  centre;

  logic             res_valid, res_frame_end;
  logic [PixW-1:0]  res_pixel;

  logic             out_valid_q, out_frame_end_q;
  logic [PixW-1:0]  out_pixel_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;
  assign accept     = in_i.valid && adv;
  assign load       = accept && item.push;
  // Fill requests inside a frame count as black pixels.
  assign pixel      = in_i.kind ? '0 : in_i.pixel_in;

  // Raster bookkeeping: decides per request whether it is pushed and what
  // kind of output pixel, if any, it brings out.
  bb5_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .fill_i   (in_i.kind),
    .item_o   (item)
  );

  // Line store stage: reads the column history and forms the vertical sum.
  bb5_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .load_i    (load),
    .item_i    (item),
    .pixel_i   (pixel),
    .b_valid_o (b_valid),
    .flags_o   (b_flags),
    .vsum_o    (vsum),
    .centre_o  (centre)
  );

  // Window stage: horizontal pass over five column sums.
  bb5_window u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .b_valid_i       (b_valid),
    .flags_i         (b_flags),
    .vsum_i          (vsum),
    .centre_i        (centre),
    .res_valid_o     (res_valid),
    .res_pixel_o     (res_pixel),
    .res_frame_end_o (res_frame_end)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_pixel_q     <= res_pixel;
      out_frame_end_q <= res_frame_end;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel_out = out_pixel_q;
  assign out_o.frame_end = out_frame_end_q;

endmodule

// ----- design/bb5_ctrl.sv -----
// ----------------------------------------------------------------------------
// bb5_ctrl: raster position tracking
// Follows the input and output raster positions and decides for each
// request whether it is pushed, whether it produces a pixel and how.
// ----------------------------------------------------------------------------
module bb5_ctrl import bb5_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic      fill_i,
  output bb5_item_t item_o
);

  logic [RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0] cur_row, cur_orow;
  logic [ColW-1:0] cur_col, cur_ocol;
  logic            restart, done, drop, started;

  always_comb begin
    // A real pixel after the frame is complete opens a new frame.
    restart  = !fill_i && (in_row_q >= RowFrame);
    cur_row  = restart ? '0 : in_row_q;
    cur_col  = restart ? '0 : in_col_q;
    cur_orow = restart ? '0 : out_row_q;
    cur_ocol = restart ? '0 : out_col_q;
    done     = !restart && (out_row_q == RowFrame);
    drop     = fill_i && done;
    started  = (cur_row > RowTwo) || ((cur_row == RowTwo) && (cur_col >= ColTwo));

    item_o.push            = !drop;
    item_o.flags.emit      = !drop && started && !done;
    item_o.flags.interior  = (cur_orow >= RowTwo) && (cur_orow <= RowInnerHi) &&
                             (cur_ocol >= ColTwo) && (cur_ocol <= ColInnerHi);
    item_o.flags.frame_end = (cur_orow == RowLast) && (cur_ocol == ColLast);
    item_o.col             = cur_col;

    if (cur_col == ColLast) begin
      in_col_d = '0;
      in_row_d = cur_row + RowW'(1);
    end else begin
      in_col_d = cur_col + ColW'(1);
      in_row_d = cur_row;
    end

    out_row_d = cur_orow;
    out_col_d = cur_ocol;
    if (item_o.flags.emit) begin
      if (cur_ocol == ColLast) begin
        out_col_d = '0;
        out_row_d = cur_orow + RowW'(1);
      end else begin
        out_col_d = cur_ocol + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (accept_i && item_o.push) begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_col_q <= ColLast)
    else $error("input column beyond frame");
  a_out_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q <= RowFrame)
    else $error("output row beyond frame");
  a_out_behind_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_row_q != RowFrame) |-> (out_row_q <= in_row_q))
    else $error("output position ahead of input position");
`endif

endmodule

// ----- design/bb5_line_buf.sv -----
// ----------------------------------------------------------------------------
// bb5_line_buf: four-line column store
// Holds the four previous rows, one 32-bit word per column, and builds the
// five-pixel column of each pushed request together with its vertical sum.
// ----------------------------------------------------------------------------
module bb5_line_buf import bb5_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             load_i,
  input  bb5_item_t        item_i,
  input  logic [PixW-1:0]  pixel_i,
  output logic             b_valid_o,
  output bb5_flags_t       flags_o,
  output logic [VsumW-1:0] vsum_o,
  output logic [PixW-1:0]  centre_o
);

  logic [Lines-1:0][PixW-1:0] mem_q [FrameSize];
  logic [Lines-1:0][PixW-1:0] rd_q, fwd_data_q, lines, wdata;
  logic [4:0][PixW-1:0]       col_b;
  logic [4:0][VsumW-1:0]      col_ext;
  logic                       b_valid_q, fwd_q, wr_en;
  logic [ColW-1:0]            b_col_q;
  logic [PixW-1:0]            px_q;
  bb5_flags_t                 b_flags_q;
  logic [HsumW-1:0]           vsum_full;

  // A column written and read at the same edge takes the written word.
  assign lines = fwd_q ? fwd_data_q : rd_q;
  assign col_b = {px_q, lines};
  assign wdata = col_b[4:1];
  assign wr_en = adv_i && b_valid_q;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      col_ext[i] = VsumW'(col_b[i]);
    end
  end

  assign vsum_full = tap_sum5(col_ext);
  assign vsum_o    = vsum_full[VsumW-1:0];
  assign centre_o  = col_b[2];
  assign b_valid_o = b_valid_q;
  assign flags_o   = b_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= load_i;
      if (load_i) begin
        fwd_q <= wr_en && (b_col_q == item_i.col);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[b_col_q] <= wdata;
    end
    if (load_i) begin
      rd_q       <= mem_q[item_i.col];
      fwd_data_q <= wdata;
      px_q       <= pixel_i;
      b_col_q    <= item_i.col;
      b_flags_q  <= item_i.flags;
    end
  end

endmodule

// ----- design/bb5_window.sv -----
// ----------------------------------------------------------------------------
// bb5_window: column-sum window and horizontal pass
// Keeps the vertical sums of the last five columns and the centre pixels,
// and forms the blurred or passed-through pixel of the window.
// ----------------------------------------------------------------------------
module bb5_window import bb5_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             b_valid_i,
  input  bb5_flags_t       flags_i,
  input  logic [VsumW-1:0] vsum_i,
  input  logic [PixW-1:0]  centre_i,
  output logic             res_valid_o,
  output logic [PixW-1:0]  res_pixel_o,
  output logic             res_frame_end_o
);

  logic [4:0][VsumW-1:0] vsum_q;
  logic [2:0][PixW-1:0]  cen_q;
  logic                  c_valid_q;
  bb5_flags_t            c_flags_q;
  logic [HsumW-1:0]      hsum;

  assign hsum            = tap_sum5(vsum_q);
  assign res_valid_o     = c_valid_q;
  assign res_pixel_o     = c_flags_q.interior ? hsum[BlurShift +: PixW] : cen_q[2];
  assign res_frame_end_o = c_flags_q.frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv_i) begin
      c_valid_q <= b_valid_i && flags_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && b_valid_i) begin
      vsum_q    <= {vsum_q[3:0], vsum_i};
      cen_q     <= {cen_q[1:0], centre_i};
      c_flags_q <= flags_i;
    end
  end

endmodule

// ----- tb/bb5_blur_checker.sv -----
// ----------------------------------------------------------------------------
// bb5_blur_checker: prediction and comparison for the 5x5 binomial blur
// Watches both stream channels. Each accepted input request but a fill past the
// frame updates a private copy of the line store, the 5x5 window and the raster
// counters, and queues the pixel, if any, that the block must emit for it.
// Each accepted result is compared field by field with the oldest queued pixel.
// ----------------------------------------------------------------------------
module bb5_blur_checker import bb5_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bb5_in_if           in_i,
  bb5_out_if          out_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FramePixels = FrameSize * FrameSize;
  localparam int unsigned Taps        = 5;
  localparam int unsigned Centre      = 2;
  localparam bit [4:0][3:0] Weights   = {4'd1, 4'd4, 4'd6, 4'd4, 4'd1};

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_end;
  } blurred_px_t;

  bit [PixW-1:0] column_hist [Lines][FrameSize];
  bit [PixW-1:0] taps_win [Taps][Taps];
  int unsigned   next_row;
  int unsigned   next_col;
  int unsigned   pixels_emitted;
  int unsigned   results_seen;
  int unsigned   mismatches;
  blurred_px_t   blurred_q [$];

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic predict_blurred_pixel(input logic is_fill, input logic [PixW-1:0] px_in);
    bit [PixW-1:0] px;
    bit [PixW-1:0] column [Taps];
    int unsigned   acc;
    int unsigned   orow;
    int unsigned   ocol;
    blurred_px_t   res;
    px = px_in;
    if (is_fill) begin
      // A fill after the whole frame has left changes nothing.
      if (pixels_emitted >= FramePixels) return;
      px = '0;
    end else if (next_row >= FrameSize) begin
      // A real pixel past the frame starts the next one and drops the tail.
      next_row       = 0;
      next_col       = 0;
      pixels_emitted = 0;
    end
    for (int i = 0; i < Lines; i++) column[i] = column_hist[i][next_col];
    column[Lines] = px;
    for (int i = 0; i < Lines; i++) column_hist[i][next_col] = column[i+1];
    for (int i = 0; i < Taps; i++) begin
      for (int j = 0; j < Taps - 1; j++) taps_win[i][j] = taps_win[i][j+1];
      taps_win[i][Taps-1] = column[i];
    end
    if ((next_row > 2 || (next_row == 2 && next_col >= 2)) && pixels_emitted < FramePixels) begin
      orow = pixels_emitted / FrameSize;
      ocol = pixels_emitted % FrameSize;
      if (orow >= 2 && orow + 2 < FrameSize && ocol >= 2 && ocol + 2 < FrameSize) begin
        acc = 0;
        for (int i = 0; i < Taps; i++) begin
          for (int j = 0; j < Taps; j++) begin
            acc += int'(taps_win[i][j]) * int'(Weights[i]) * int'(Weights[j]);
          end
        end
        res.pixel = PixW'(acc >> BlurShift);
      end else begin
        res.pixel = taps_win[Centre][Centre];
      end
      res.frame_end = (pixels_emitted == FramePixels - 1);
      blurred_q.push_back(res);
      pixels_emitted++;
    end
    next_col++;
    if (next_col >= FrameSize) begin
      next_col = 0;
      next_row++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    blurred_px_t want;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready) predict_blurred_pixel(in_i.kind, in_i.pixel_in);
      if (out_i.valid && out_i.ready) begin
        if (blurred_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrives with none expected", results_seen));
        end else begin
          want = blurred_q.pop_front();
          if (out_i.pixel_out !== want.pixel) begin
            report_mismatch($sformatf("result %0d: pixel_out %0d, expected %0d",
                                      results_seen, out_i.pixel_out, want.pixel));
          end
          if (out_i.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("result %0d: frame_end %0b, expected %0b",
                                      results_seen, out_i.frame_end, want.frame_end));
          end
        end
        results_seen++;
      end
      pending_o <= blurred_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the 5x5 binomial blur
// Streams the first rows of a 256x256 frame of patterned and random pixels,
// with scattered fill requests inside the frame, pauses once until every
// result is in, and stalls both channels at random, including one long
// hold-off on the result side. A separate checker predicts every output
// pixel and counts faults.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bb5_pkg::*;

  // Request kinds on the input channel.
  localparam logic KindPixel = 1'b0;
  localparam logic KindFill  = 1'b1;

  // Requests sent in all, and the raster position at which the sender
  // pauses until the block has given back every result.
  localparam int unsigned ItemCount    = 1650;
  localparam int unsigned PauseAt      = 1000;
  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned HoldCycles   = 600;
  // The long hold-off starts once results are already flowing.
  localparam int unsigned HoldAt       = 3 * FrameSize + 40;
  localparam int unsigned MaxPause     = 24;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned DrainLimit   = 5000;
  // Worst case per request: the longest sender gap, the longest receiver
  // stall and the block's own delay; then taken three times over, with
  // room for the hold-off and both drain waits.
  localparam int unsigned CycleLimit   =
      (ItemCount + 64) * (2 * MaxPause + 8) * 3 + 4 * HoldCycles + 2 * DrainLimit;

  // Content styles of a band of eight rows. Flat areas and stripes reach the
  // extremes of the weighted sum, which plain noise hardly ever does.
  typedef enum logic [2:0] {PatNoise, PatBright, PatDark, PatStripes, PatFlat} pattern_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycles;

  // Receiver state, owned by the receiver process apart from hold_ask.
  int unsigned hold_ask;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned stretch_left;
  bit          rx_calm;

  // Sender state.
  bit              tx_calm;
  pattern_e        pattern;
  logic [PixW-1:0] flat_level;

  bb5_in_if  in_ch ();
  bb5_out_if out_ch ();

  binomial_blur_5x5 uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  bb5_blur_checker blur_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Safety net: a hung handshake must not run for ever.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Pause length shared by both sides: mostly none, often a short one,
  // now and then a long one.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, MaxPause);
  endfunction

  // Receiver. It alternates between calm stretches, in which it draws no new
  // stalls, and stretches with random stalls. A hold-off request from the
  // stimulus makes it refuse results for the whole hold-off, counted down here,
  // so that the block backs up and has to refuse input requests itself.
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(64, 512);
        rx_calm      = ($urandom_range(0, 2) == 0);
      end else begin
        stretch_left--;
      end
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!rx_calm) stall_left = pick_pause();
      end
    end
  end

  // Offers one request and returns at the clock edge that accepts it. The
  // valid line is only lowered when a gap is actually taken, so it never
  // gets two assignments in one time step.
  task automatic push_pixel(input logic kind, input logic [PixW-1:0] value);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_pause();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.pixel_in <= value;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Sends raster positions first .. stop-1 of a frame. The content style is
  // drawn afresh for every band of eight rows, the sender switches between
  // calm rows and rows with gaps, and roughly one request in two hundred is
  // a fill inside the frame, which the block must treat as a black pixel.
  task automatic stream_pixels(input int unsigned first, input int unsigned stop);
    int unsigned     row;
    int unsigned     col;
    int unsigned     r;
    logic [PixW-1:0] value;
    logic            kind;
    for (int unsigned p = first; p < stop; p++) begin
      row = p / FrameSize;
      col = p % FrameSize;
      if (p == first || (col == 0 && row % 8 == 0)) begin
        r          = $urandom_range(0, 9);
        pattern    = (r < 5) ? PatNoise : (r == 5) ? PatBright : (r == 6) ? PatDark :
                     (r == 7) ? PatStripes : PatFlat;
        flat_level = PixW'($urandom_range(0, 255));
      end
      if (col == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (p == HoldAt) hold_ask <= hold_ask + 1;
      case (pattern)
        PatNoise:   value = PixW'($urandom_range(0, 255));
        PatBright:  value = '1;
        PatDark:    value = '0;
        PatStripes: value = ((row ^ col) & 1) ? '1 : '0;
        default:    value = flat_level;
      endcase
      kind = ($urandom_range(0, 199) == 0) ? KindFill : KindPixel;
      push_pixel(kind, value);
    end
  endtask

  // Stops offering and waits until every predicted pixel has been received
  // or the wait has reached the drain limit.
  task automatic pause_until_drained();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DrainLimit);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KindPixel;
    in_ch.pixel_in <= '0;
    tx_calm         = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening of the frame: a fill as the very first request
    // (a black pixel at the top left corner), the pixel extremes, alternating
    // bit patterns, and further fills, whose payloads are ignored.
    push_pixel(KindFill,  8'hFF);
    push_pixel(KindPixel, 8'h00);
    push_pixel(KindPixel, 8'hFF);
    push_pixel(KindPixel, 8'h55);
    push_pixel(KindPixel, 8'hAA);
    push_pixel(KindPixel, 8'h01);
    push_pixel(KindPixel, 8'h80);
    push_pixel(KindPixel, 8'h7F);
    push_pixel(KindPixel, 8'hFE);
    push_pixel(KindFill,  8'h00);
    push_pixel(KindFill,  8'h5A);
    push_pixel(KindPixel, 8'hFF);

    // The first rows, with the long hold-off on the result side inside them,
    // then a pause until every result has come back.
    stream_pixels(12, PauseAt);
    pause_until_drained();

    // The following rows, restarted from an empty pipeline.
    stream_pixels(PauseAt, ItemCount);

    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending != 0) $display("%0d expected pixels never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
